FILE: hdl/contiguous_fit_allocator_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define CFA_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// Next-cycle implication.
`define CFA_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

FILE: hdl/cfa_pkg.sv
package cfa_pkg;

	localparam int OP_W     = 2;
	localparam int OWNER_W  = 16;
	localparam int SIZE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int START_W  = 7;
	localparam int LEN_W    = 8;
	localparam int POLICY_W = 2;
	localparam int AGE_W    = 16;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd3;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [OWNER_W-1:0] owner_id;
		logic [SIZE_W-1:0]  request_size;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  start_unit;
		logic [LEN_W-1:0]    run_length;
	} rsp_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: hdl/cfa_if.sv
interface cfa_req_if;
	import cfa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cfa_rsp_if;
	import cfa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cfa_cfg_if;
	import cfa_pkg::*;
	logic valid;
	logic ready;
	logic [POLICY_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/cfa_unit_cell.sv
module cfa_unit_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cfa_pkg::cell_ctrl_t ctrl,
	input  logic              nbr,
	output logic              used
);
	logic used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctrl.clear) begin
			used_q <= 1'b0;
		end else if (ctrl.shift) begin
			used_q <= nbr;
		end
	end

	assign used = used_q;
endmodule

FILE: hdl/cfa_entry_store.sv
module cfa_entry_store #(
	parameter int DW    = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hdl/contiguous_fit_allocator.sv
// Contiguous fit allocator. The unit map is a ring of UNITS one-bit cells that
// rotates one place per cycle, while a run is scanned or marked, past a single
// scan point; the allocation table is a memory with a write port and a read
// port, swept one entry per cycle. One request is worked at a time. Allocate:
// decode, lowest free table index search, run scan, marking rotation, response.
// Release: decode, table sweep, freeing rotation, response. A failed search
// skips the rotation; clear and rejected requests respond after decode. The
// next request is taken while the last result still waits in the output register.
module contiguous_fit_allocator #(
	parameter int UNITS         = 128,
	parameter int TABLE_ENTRIES = 128
) (
	input  logic clk,
	input  logic arst_n,
	cfa_cfg_if.sink   cfg,
	cfa_req_if.sink   req,
	cfa_rsp_if.source rsp
);
	import cfa_pkg::*;
	`include "contiguous_fit_allocator_macros.svh"

	localparam int UIW = $clog2(UNITS);
	localparam int UCW = $clog2(UNITS + 1);
	localparam int TIW = $clog2(TABLE_ENTRIES);
	localparam int TCW = $clog2(TABLE_ENTRIES + 1);

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [AGE_W-1:0]   age;
		logic [UIW-1:0]     start;
		logic [LEN_W-1:0]   len;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SLOT, S_RUN, S_MARK, S_REL, S_RESP
	} state_t;

	state_t                state_q;
	logic [POLICY_W-1:0]   policy_q;
	logic [OP_W-1:0]       op_q;
	logic [OWNER_W-1:0]    owner_q;
	logic [SIZE_W-1:0]     size_q;
	logic [UCW-1:0]        cnt_q;
	logic [TCW-1:0]        tk_q;
	logic [TIW-1:0]        slot_q;
	logic [UCW-1:0]        run_start_q;
	logic [UIW-1:0]        chosen_q;
	logic [UCW-1:0]        best_len_q;
	logic                  found_q;
	logic [UIW-1:0]        mark_start_q;
	logic [LEN_W-1:0]      mark_len_q;
	logic                  mark_val_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]      next_age_q;
	logic [AGE_W-1:0]      best_rank_q;
	logic [TIW-1:0]        rel_idx_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [UIW-1:0]        res_start_q;
	logic [LEN_W-1:0]      res_len_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_data_q;
	logic                  pend_s1;
	logic [TIW-1:0]        idx_s1;
	logic                  vld_s1;

	// unit ring
	logic [UNITS-1:0] used;
	logic [UNITS-1:0] nbr;
	cell_ctrl_t       cell_ctrl;
	logic             mark_hit;
	logic             ring_in;

	// run scan
	logic             at_end;
	logic             boundary;
	logic [15:0]      len16;
	logic             fits;
	logic             take;
	logic             hit;
	logic             found_nx;
	logic [UIW-1:0]   chosen_nx;

	// table
	logic             mem_we;
	entry_t           mem_wdata;
	entry_t           mem_rdata;
	logic [TIW-1:0]   mem_raddr;
	logic [AGE_W-1:0] rank;
	logic             rel_hit;
	logic [UIW+START_W-1:0] start_ext;

	always_comb begin
		mark_hit = (16'(cnt_q) >= 16'(mark_start_q)) &&
			(16'(cnt_q) < 16'(mark_start_q) + 16'(mark_len_q));
		ring_in = (state_q == S_MARK && mark_hit) ? mark_val_q : used[0];
		nbr = {ring_in, used[UNITS-1:1]};
		cell_ctrl.shift = (state_q == S_RUN && cnt_q != UCW'(UNITS)) || state_q == S_MARK;
		cell_ctrl.clear = state_q == S_DECODE && op_q == OP_CLEAR;
	end

	for (genvar i = 0; i < UNITS; i++) begin : g_cell
		cfa_unit_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.nbr    (nbr[i]),
			.used   (used[i])
		);
	end

	always_comb begin
		at_end   = cnt_q == UCW'(UNITS);
		boundary = at_end || used[0];
		len16    = 16'(cnt_q) - 16'(run_start_q);
		fits     = len16 >= 16'(size_q);
		case (policy_q)
			POL_FIRST: take = !found_q;
			POL_WORST: take = !found_q || len16 > 16'(best_len_q);
			POL_BEST:  take = !found_q || len16 < 16'(best_len_q) ||
				(at_end && len16 == 16'(best_len_q));
			default:   take = 1'b0;
		endcase
		hit       = boundary && fits && take;
		found_nx  = found_q || hit;
		chosen_nx = hit ? run_start_q[UIW-1:0] : chosen_q;
	end

	assign mem_we          = state_q == S_RUN && at_end && found_nx;
	assign mem_wdata.owner = owner_q;
	assign mem_wdata.age   = next_age_q;
	assign mem_wdata.start = chosen_nx;
	assign mem_wdata.len   = size_q;
	assign mem_raddr       = tk_q[TIW-1:0];

	cfa_entry_store #(
		.DW    ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rank      = mem_rdata.age - next_age_q;
	assign rel_hit   = pend_s1 && vld_s1 && mem_rdata.owner == owner_q &&
		(!found_q || rank < best_rank_q);
	assign start_ext = {{START_W{1'b0}}, res_start_q};

	assign cfg.ready = 1'b1;
	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FIRST;
			op_q         <= OP_ALLOC;
			owner_q      <= '0;
			size_q       <= '0;
			cnt_q        <= '0;
			tk_q         <= '0;
			slot_q       <= '0;
			run_start_q  <= '0;
			chosen_q     <= '0;
			best_len_q   <= '0;
			found_q      <= 1'b0;
			mark_start_q <= '0;
			mark_len_q   <= '0;
			mark_val_q   <= 1'b0;
			valid_q      <= '0;
			next_age_q   <= '0;
			best_rank_q  <= '0;
			rel_idx_q    <= '0;
			res_status_q <= ST_DONE;
			res_start_q  <= '0;
			res_len_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			pend_s1      <= 1'b0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
		end else begin
			if (cfg.valid) begin
				policy_q <= cfg.data;
			end
			// output register frees on a taken beat and refills from S_RESP
			if (rsp.ready || !rsp_valid_q) begin
				rsp_valid_q <= state_q == S_RESP;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.data.operation;
						owner_q <= req.data.owner_id;
						size_q  <= req.data.request_size;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_status_q <= ST_DONE;
					res_start_q  <= '0;
					res_len_q    <= '0;
					tk_q         <= '0;
					found_q      <= 1'b0;
					pend_s1      <= 1'b0;
					case (op_q)
						OP_ALLOC: begin
							if (size_q == '0 || 16'(size_q) > 16'(UNITS)) begin
								res_status_q <= ST_BAD_SIZE;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_SLOT;
							end
						end
						OP_RELEASE: state_q <= S_REL;
						OP_CLEAR: begin
							valid_q    <= '0;
							next_age_q <= '0;
							state_q    <= S_RESP;
						end
						default: begin
							res_status_q <= ST_BAD_SIZE;
							state_q      <= S_RESP;
						end
					endcase
				end
				S_SLOT: begin
					if (tk_q == TCW'(TABLE_ENTRIES)) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_RESP;
					end else if (!valid_q[tk_q[TIW-1:0]]) begin
						slot_q      <= tk_q[TIW-1:0];
						cnt_q       <= '0;
						run_start_q <= '0;
						state_q     <= S_RUN;
					end else begin
						tk_q <= tk_q + 1'b1;
					end
				end
				S_RUN: begin
					found_q  <= found_nx;
					chosen_q <= chosen_nx;
					if (hit) begin
						best_len_q <= len16[UCW-1:0];
					end
					if (boundary) begin
						run_start_q <= cnt_q + 1'b1;
					end
					if (at_end) begin
						cnt_q <= '0;
						if (found_nx) begin
							valid_q[slot_q] <= 1'b1;
							next_age_q      <= next_age_q + 1'b1;
							mark_start_q    <= chosen_nx;
							mark_len_q      <= size_q;
							mark_val_q      <= 1'b1;
							res_start_q     <= chosen_nx;
							res_len_q       <= size_q;
							state_q         <= S_MARK;
						end else begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_RESP;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MARK: begin
					if (cnt_q == UCW'(UNITS - 1)) begin
						state_q <= S_RESP;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_REL: begin
					// table read data returns in the cycle after the address
					pend_s1 <= tk_q != TCW'(TABLE_ENTRIES);
					idx_s1  <= tk_q[TIW-1:0];
					vld_s1  <= valid_q[tk_q[TIW-1:0]];
					if (tk_q != TCW'(TABLE_ENTRIES)) begin
						tk_q <= tk_q + 1'b1;
					end
					if (rel_hit) begin
						found_q     <= 1'b1;
						best_rank_q <= rank;
						rel_idx_q   <= idx_s1;
						res_start_q <= mem_rdata.start;
						res_len_q   <= mem_rdata.len;
					end
					if (tk_q == TCW'(TABLE_ENTRIES) && !pend_s1) begin
						cnt_q <= '0;
						if (found_q) begin
							valid_q[rel_idx_q] <= 1'b0;
							mark_start_q       <= res_start_q;
							mark_len_q         <= res_len_q;
							mark_val_q         <= 1'b0;
							state_q            <= S_MARK;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_data_q.status     <= res_status_q;
						rsp_data_q.start_unit <= start_ext[START_W-1:0];
						rsp_data_q.run_length <= res_len_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CFA_ASSERT_NXT(a_one_item_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready)
	`CFA_ASSERT_NXT(a_clear_empties, clk, arst_n, state_q == S_DECODE && op_q == OP_CLEAR, valid_q == '0 && used == '0 && next_age_q == '0)
	`CFA_ASSERT_IMP(a_mark_in_ring, clk, arst_n, state_q == S_MARK, cnt_q < UCW'(UNITS))
endmodule

FILE: tb/cfa_tb_if.sv
`timescale 1ns / 100ps
// Testbench side of the channels lives in the RTL interface file; this file only
// holds a small beat record shared by the testbench top.
package cfa_tb_pkg;
	import cfa_pkg::*;

	typedef struct {
		req_t beat;
		bit   hold_for_drain;
	} stim_t;
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import cfa_pkg::*;
	import cfa_tb_pkg::*;

	localparam int NUNITS   = 128;
	localparam int NENTRIES = 128;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cfa_cfg_if cfg();
	cfa_req_if req();
	cfa_rsp_if rsp();

	contiguous_fit_allocator #(.UNITS(NUNITS), .TABLE_ENTRIES(NENTRIES)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// allocator shadow state
	logic [POLICY_W-1:0] sh_policy;
	bit                  sh_used [NUNITS];
	bit                  sh_valid [NENTRIES];
	logic [OWNER_W-1:0]  sh_owner [NENTRIES];
	logic [START_W-1:0]  sh_start [NENTRIES];
	logic [LEN_W-1:0]    sh_len [NENTRIES];
	logic [AGE_W-1:0]    sh_age [NENTRIES];
	logic [AGE_W-1:0]    sh_next_age;

	stim_t pending_reqs[$];
	rsp_t  expected_rsps[$];
	int    fail_count = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	bit    drain_hold = 1'b0;
	bit    req_taken = 1'b0;

	function automatic int find_run(int size, logic [POLICY_W-1:0] pol);
		int chosen, best, run_start, len;
		bit at_end;
		chosen = -1;
		best = 0;
		run_start = 0;
		for (int i = 0; i <= NUNITS; i++) begin
			at_end = (i == NUNITS);
			if (at_end || sh_used[i]) begin
				len = i - run_start;
				if (len >= size) begin
					if (pol == POL_FIRST) begin
						if (chosen < 0) chosen = run_start;
					end else if (pol == POL_WORST) begin
						if (chosen < 0 || len > best) begin
							chosen = run_start;
							best = len;
						end
					end else if (pol == POL_BEST) begin
						if (chosen < 0 || len < best || (at_end && len == best)) begin
							chosen = run_start;
							best = len;
						end
					end
				end
				run_start = i + 1;
			end
		end
		return chosen;
	endfunction

	function automatic rsp_t allocator_outcome(req_t r);
		rsp_t o;
		int slot, at, found;
		logic [AGE_W-1:0] rank, best_rank;
		o = '0;
		slot = -1;
		found = -1;
		best_rank = '0;
		if (r.operation == OP_ALLOC) begin
			if (r.request_size == 0 || r.request_size > NUNITS) begin
				o.status = ST_BAD_SIZE;
			end else begin
				for (int k = 0; k < NENTRIES; k++)
					if (!sh_valid[k] && slot < 0) slot = k;
				at = (slot < 0) ? -1 : find_run(int'(r.request_size), sh_policy);
				if (at < 0) begin
					o.status = ST_NO_SPACE;
				end else begin
					o.status = ST_DONE;
					o.start_unit = at[START_W-1:0];
					o.run_length = r.request_size;
					for (int i = at; i < at + r.request_size; i++) sh_used[i] = 1'b1;
					sh_valid[slot] = 1'b1;
					sh_owner[slot] = r.owner_id;
					sh_start[slot] = at[START_W-1:0];
					sh_len[slot] = r.request_size;
					sh_age[slot] = sh_next_age;
					sh_next_age++;
				end
			end
		end else if (r.operation == OP_RELEASE) begin
			for (int k = 0; k < NENTRIES; k++) begin
				if (sh_valid[k] && sh_owner[k] == r.owner_id) begin
					rank = sh_age[k] - sh_next_age;
					if (found < 0 || rank < best_rank) begin
						found = k;
						best_rank = rank;
					end
				end
			end
			if (found < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.status = ST_DONE;
				o.start_unit = sh_start[found];
				o.run_length = sh_len[found];
				for (int i = sh_start[found]; i < sh_start[found] + sh_len[found]; i++)
					sh_used[i] = 1'b0;
				sh_valid[found] = 1'b0;
			end
		end else if (r.operation == OP_CLEAR) begin
			for (int i = 0; i < NUNITS; i++) sh_used[i] = 1'b0;
			for (int k = 0; k < NENTRIES; k++) sh_valid[k] = 1'b0;
			sh_next_age = '0;
			o.status = ST_DONE;
		end else begin
			o.status = ST_BAD_SIZE;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// request driver; a beat stays up until the rising edge that takes it
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || req_taken) begin
				if (pending_reqs.size() > 0 && !drain_hold
					&& $urandom_range(99) >= send_idle_pct) begin
					if (pending_reqs[0].hold_for_drain && expected_rsps.size() > 0) begin
						req.valid <= 1'b0;
					end else begin
						req.data <= pending_reqs[0].beat;
						req.valid <= 1'b1;
						void'(pending_reqs.pop_front());
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// predictor runs on accepted requests, checker on accepted results
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n) begin
			req_taken <= req.valid && req.ready;
			if (req.valid && req.ready)
				expected_rsps = {expected_rsps, allocator_outcome(req.data)};
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_rsps.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.start_unit !== want.start_unit)
						report_mismatch("start_unit", got.start_unit, want.start_unit);
					if (got.run_length !== want.run_length)
						report_mismatch("run_length", got.run_length, want.run_length);
				end
			end
		end
	end

	task automatic add_req(logic [OP_W-1:0] op, logic [OWNER_W-1:0] own,
		logic [SIZE_W-1:0] size, bit hold = 1'b0);
		stim_t s;
		s.beat.operation = op;
		s.beat.owner_id = own;
		s.beat.request_size = size;
		s.hold_for_drain = hold;
		pending_reqs = {pending_reqs, s};
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		// then let the clock run on idle before the next phase
		repeat (NUNITS * 2 + NENTRIES + 20) @(posedge clk);
	endtask

	task automatic write_policy(logic [POLICY_W-1:0] pol);
		@(negedge clk);
		cfg.data <= pol;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sh_policy = pol;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		logic [OWNER_W-1:0] own;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			own = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
			if (pick < 55)
				add_req(OP_ALLOC, own, ($urandom_range(19) == 0) ? 8'($urandom)
					: 8'($urandom_range(1, ($urandom_range(9) == 0) ? 128 : 24)));
			else if (pick < 93)
				add_req(OP_RELEASE, own, 8'($urandom));
			else if (pick < 97)
				add_req(OP_CLEAR, own, 8'($urandom));
			else
				add_req(OP_UNUSED, own, 8'($urandom));
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		sh_policy = POL_FIRST;
		sh_next_age = '0;
		for (int i = 0; i < NUNITS; i++) sh_used[i] = 1'b0;
		for (int k = 0; k < NENTRIES; k++) sh_valid[k] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: size extremes, every operation, tie rules, unused op
		add_req(OP_ALLOC, 16'h0000, 8'd0);
		add_req(OP_ALLOC, 16'hFFFF, 8'd129);
		add_req(OP_ALLOC, 16'hFFFF, 8'd255);
		add_req(OP_RELEASE, 16'h1234, 8'd0);
		add_req(OP_ALLOC, 16'hFFFF, 8'd128);
		add_req(OP_ALLOC, 16'h0001, 8'd1);
		add_req(OP_RELEASE, 16'hFFFF, 8'd0);
		add_req(OP_ALLOC, 16'h0001, 8'd10);
		add_req(OP_ALLOC, 16'h0002, 8'd5);
		add_req(OP_ALLOC, 16'h0001, 8'd20);
		add_req(OP_RELEASE, 16'h0001, 8'd0);
		add_req(OP_UNUSED, 16'hAAAA, 8'hAA);
		add_req(OP_RELEASE, 16'h0001, 8'd0, 1'b1);
		add_req(OP_CLEAR, 16'h5555, 8'h55);
		add_req(OP_RELEASE, 16'h0002, 8'd0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_policy(POLICY_W'(ph % 4));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (ph == 4) begin
				// table full path: many one-unit allocations from an empty map
				add_req(OP_CLEAR, 16'd0, 8'd0);
				for (int i = 0; i < 130; i++) add_req(OP_ALLOC, 16'(i), 8'd1);
				add_req(OP_CLEAR, 16'd0, 8'd0);
			end
			random_phase(ph == 4 ? 110 : 240);
			wait_drained();
		end
		write_policy(POL_BEST);

		if (fail_count == 0)
			$display("contiguous_fit_allocator verification clean");
		else
			$display("contiguous_fit_allocator verification failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("contiguous_fit_allocator verification failed");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/cfa_pkg.sv
hdl/cfa_if.sv
hdl/cfa_unit_cell.sv
hdl/cfa_entry_store.sv
hdl/contiguous_fit_allocator.sv
tb/cfa_tb_if.sv
tb/testbench.sv
